// ===== sv/mrfp_pkg.sv =====
// Shared types and constants of the meter reply frame parser.
// No dependencies; every other file imports this package.
package mrfp_pkg;

	localparam int STORE_DEPTH = 16;
	localparam int SP_W        = $clog2(STORE_DEPTH);
	localparam int Q_DEPTH     = 2;
	localparam int QA_W        = $clog2(Q_DEPTH);
	localparam int QC_W        = $clog2(Q_DEPTH + 1);
	localparam int POS_W       = 11;
	localparam int RV_W        = 28;

	localparam logic [POS_W-1:0] POS_MAX     = 11'd2047;
	localparam logic [7:0]       HEADER_BYTE = 8'h06;
	localparam int               REC_LEN     = 7;
	localparam int               END_OFS     = 8;
	localparam int               TAIL_LEN    = 14;
	localparam int               SCALE_HI    = 1000000;
	localparam int               SCALE_LO    = 1000;

	typedef enum logic {
		CMD_BYTE    = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IN_FRAME   = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_FRAME_OK   = 3'd2,
		ST_BAD_SUM    = 3'd3,
		ST_AFTER      = 3'd4,
		ST_RESTART    = 3'd5
	} status_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [7:0]      record_count;
		logic [RV_W-1:0] reading_value;
		logic [4:0]      year_code;
		logic [3:0]      month_code;
		logic [4:0]      day_code;
		logic [4:0]      hour_code;
		logic [5:0]      minute_code;
	} rsp_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [7:0]       data;
		logic [POS_W-1:0] end_cand;
	} qent_t;

endpackage

// ===== sv/mrfp_front.sv =====
// Front stage: takes input beats, classifies them and precomputes the frame end.
// Depends on mrfp_pkg.
module mrfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mrfp_pkg::req_t req,
	output logic          push,
	output mrfp_pkg::qent_t push_ent,
	input  logic          q_full
);
	import mrfp_pkg::*;

	logic  valid_s1;
	qent_t ent_s1;
	qent_t ent_d;

	always_comb begin
		ent_d.cmd      = cmd_t'(req.opcode);
		ent_d.data     = req.rx_byte;
		ent_d.end_cand = POS_W'(req.rx_byte) * POS_W'(REC_LEN) + POS_W'(END_OFS);
	end

	assign push      = valid_s1 && !q_full;
	assign req_stall = valid_s1 && q_full;
	assign push_ent  = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			ent_s1 <= ent_d;
		end
	end

endmodule

// ===== sv/mrfp_queue.sv =====
// Short queue between front and back stages.
// Depends on mrfp_pkg.
module mrfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrfp_pkg::qent_t push_ent,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mrfp_pkg::qent_t head
);
	import mrfp_pkg::*;

	qent_t           mem_q [Q_DEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;

	assign full      = (cnt_q == QC_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QA_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QA_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

endmodule

// ===== sv/mrfp_back.sv =====
// Back stage: frame state, tail store, checksum and result decode with output register.
// Depends on mrfp_pkg.
module mrfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mrfp_pkg::qent_t q_head,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mrfp_pkg::rsp_t  rsp
);
	import mrfp_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d, pos_nx;
	logic [POS_W-1:0] end_q, end_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [SP_W-1:0]  ptr_q, ptr_d;
	logic [7:0]       tail_q [STORE_DEPTH];
	logic [7:0]       tail_d [STORE_DEPTH];
	status_t          st;
	logic             clr;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	assign pop       = q_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		pos_d  = pos_q;
		end_d  = end_q;
		sum_d  = sum_q;
		cnt_d  = cnt_q;
		ptr_d  = ptr_q;
		tail_d = tail_q;
		st     = ST_AFTER;
		clr    = 1'b0;
		pos_nx = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		if (q_head.cmd == CMD_RESTART) begin
			clr = 1'b1;
			st  = ST_RESTART;
		end else begin
			pos_d = pos_nx;
			if (pos_nx == POS_W'(1)) begin
				if (q_head.data != HEADER_BYTE) begin
					clr = 1'b1;
					st  = ST_BAD_HEADER;
				end else begin
					st = ST_IN_FRAME;
				end
			end else if (pos_nx == POS_W'(2)) begin
				cnt_d = q_head.data;
				end_d = q_head.end_cand;
				sum_d = q_head.data;
				st    = ST_IN_FRAME;
			end else if (pos_nx <= end_q) begin
				sum_d = sum_q + q_head.data;
				st    = ST_IN_FRAME;
				if (end_q >= POS_W'(TAIL_LEN) &&
				    ({1'b0, pos_nx} + (POS_W + 1)'(TAIL_LEN)) > {1'b0, end_q}) begin
					tail_d[ptr_q] = q_head.data;
					ptr_d = (ptr_q == SP_W'(STORE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				end
			end else if ({1'b0, pos_nx} == {1'b0, end_q} + 1'b1) begin
				if (q_head.data != sum_q) begin
					clr = 1'b1;
					st  = ST_BAD_SUM;
				end else begin
					st = ST_FRAME_OK;
				end
			end
		end
		if (clr) begin
			pos_d  = '0;
			end_d  = '0;
			sum_d  = '0;
			cnt_d  = '0;
			ptr_d  = '0;
			tail_d = '{default: '0};
		end
	end

	always_comb begin
		rsp_d.status        = st;
		rsp_d.record_count  = cnt_d;
		rsp_d.reading_value = RV_W'(tail_d[0]) * RV_W'(SCALE_HI)
		                    + RV_W'(tail_d[1]) * RV_W'(SCALE_LO)
		                    + RV_W'(tail_d[2]);
		rsp_d.year_code     = {tail_d[6][7], tail_d[3][7:4]};
		rsp_d.month_code    = tail_d[3][3:0];
		rsp_d.day_code      = tail_d[4][7:3];
		rsp_d.hour_code     = {tail_d[4][2:0], tail_d[5][7:6]};
		rsp_d.minute_code   = tail_d[5][5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			end_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			tail_q      <= '{default: '0};
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q  <= pos_d;
				end_q  <= end_d;
				sum_q  <= sum_d;
				cnt_q  <= cnt_d;
				ptr_q  <= ptr_d;
				tail_q <= tail_d;
			end
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== sv/meter_reply_frame_parser_unit.sv =====
// Top level of the meter reply frame parser: front stage, queue, back stage.
// Depends on mrfp_pkg, mrfp_front, mrfp_queue, mrfp_back.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | mrfp_pkg::req_t (opcode, rx_byte)
//   rsp     | out | rsp_valid/rsp_stall  | mrfp_pkg::rsp_t (status and decoded fields)
//
// One beat per cycle sustained while rsp is not stalled; every req beat gives exactly one rsp beat.
// The path runs through the front register, the two-entry queue and the back output register.
// Frame state and the tail store update in the back stage once per beat.
// arst_n clears all frame state and the tail store to zero.
// A stalled rsp only stalls the back stage; the front keeps taking beats until the queue fills.
module meter_reply_frame_parser_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mrfp_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mrfp_pkg::rsp_t  rsp
);
	import mrfp_pkg::*;

	logic  push;
	qent_t push_ent;
	logic  q_full;
	logic  pop;
	logic  q_valid;
	qent_t q_head;

	mrfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_ent  (push_ent),
		.q_full    (q_full)
	);

	mrfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	mrfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== sv/mrfp_checker.sv =====
// Port-level checks of the meter reply frame parser, bound to the top level.
// Depends on mrfp_pkg and meter_reply_frame_parser_unit.
module mrfp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input mrfp_pkg::rsp_t rsp
);
	import mrfp_pkg::*;

	logic [2:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = req_valid && !req_stall;
	assign out_beat = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("rsp beat without an outstanding req beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more beats in flight than pipeline holds");

	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_RESTART |->
			rsp.record_count == 8'd0 && rsp.reading_value == '0)
		else $error("restart did not clear state");

	a_header_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_BAD_HEADER || rsp.status == ST_BAD_SUM) |->
			rsp.record_count == 8'd0 && rsp.minute_code == 6'd0)
		else $error("frame error did not clear state");

endmodule

bind meter_reply_frame_parser_unit mrfp_checker u_mrfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== dv/tb_meter_reply_frame_parser_unit.sv =====
// Testbench for meter_reply_frame_parser_unit: directed table, random reply frames, then a larger frame.
// Every accepted rsp beat is checked against an in-bench model of the frame parser, or against its table row.
// Depends on mrfp_pkg and the RTL of meter_reply_frame_parser_unit.
`timescale 1ns / 1ps

module tb_meter_reply_frame_parser_unit;
	import mrfp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RAND_BEATS  = 380;

	typedef struct {
		req_t beat;
		bit   fixed;
		rsp_t want;
	} stim_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	stim_t cur_item;
	stim_t dir_tab[$];
	rsp_t  reply_q[$];

	// parser model state
	logic [POS_W-1:0] frm_pos;
	logic [POS_W-1:0] frm_end;
	logic [7:0]       frm_sum;
	logic [7:0]       frm_cnt;
	logic [SP_W-1:0]  tail_ptr;
	logic [7:0]       tail_mem[STORE_DEPTH];

	int beats_sent   = 0;
	int replies_seen = 0;
	int fail_cnt     = 0;
	int stuck        = 0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;

	meter_reply_frame_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_frame();
		frm_pos  = '0;
		frm_end  = '0;
		frm_sum  = '0;
		frm_cnt  = '0;
		tail_ptr = '0;
		foreach (tail_mem[i]) tail_mem[i] = '0;
	endfunction

	function automatic rsp_t predict_reply(req_t r);
		rsp_t       o;
		status_t    st;
		logic [7:0] b;
		b = r.rx_byte;
		if (r.opcode == CMD_RESTART) begin
			clear_frame();
			st = ST_RESTART;
		end else begin
			if (frm_pos < POS_MAX) frm_pos++;
			if (frm_pos == 1) begin
				if (b != HEADER_BYTE) begin
					clear_frame();
					st = ST_BAD_HEADER;
				end else begin
					st = ST_IN_FRAME;
				end
			end else if (frm_pos == 2) begin
				frm_cnt = b;
				frm_end = POS_W'(b) * POS_W'(REC_LEN) + POS_W'(END_OFS);
				frm_sum = b;
				st = ST_IN_FRAME;
			end else if (frm_pos <= frm_end) begin
				frm_sum = frm_sum + b;
				if (frm_end >= TAIL_LEN && frm_pos > frm_end - TAIL_LEN) begin
					tail_mem[tail_ptr] = b;
					tail_ptr++;
				end
				st = ST_IN_FRAME;
			end else if (frm_pos == frm_end + 1) begin
				if (b != frm_sum) begin
					clear_frame();
					st = ST_BAD_SUM;
				end else begin
					st = ST_FRAME_OK;
				end
			end else begin
				st = ST_AFTER;
			end
		end
		o.status        = st;
		o.record_count  = frm_cnt;
		o.reading_value = RV_W'(int'(tail_mem[0]) * SCALE_HI + int'(tail_mem[1]) * SCALE_LO
			+ int'(tail_mem[2]));
		o.year_code     = {tail_mem[6][7], tail_mem[3][7:4]};
		o.month_code    = tail_mem[3][3:0];
		o.day_code      = tail_mem[4][7:3];
		o.hour_code     = {tail_mem[4][2:0], tail_mem[5][7:6]};
		o.minute_code   = tail_mem[5][5:0];
		return o;
	endfunction

	function automatic string fmt_reply(rsp_t r);
		return $sformatf("st=%0d cnt=%0d rv=%0d y=%0d mo=%0d d=%0d h=%0d mi=%0d",
			r.status, r.record_count, r.reading_value, r.year_code, r.month_code,
			r.day_code, r.hour_code, r.minute_code);
	endfunction

	function automatic stim_t row(cmd_t op, logic [7:0] b, bit fixed, status_t st,
		logic [7:0] cnt);
		stim_t s;
		s.beat.opcode        = op;
		s.beat.rx_byte       = b;
		s.fixed              = fixed;
		s.want               = '0;
		s.want.status        = st;
		s.want.record_count  = cnt;
		return s;
	endfunction

	always @(posedge clk) begin : monitor
		rsp_t want;
		bit   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (req_valid && !req_stall) begin
				want = predict_reply(req);
				if (cur_item.fixed) want = cur_item.want;
				reply_q.push_back(want);
				moved = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (reply_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10) $display("unexpected rsp beat: %s", fmt_reply(rsp));
				end else begin
					want = reply_q.pop_front();
					if (rsp.status !== want.status || rsp.record_count !== want.record_count
						|| rsp.reading_value !== want.reading_value
						|| rsp.year_code !== want.year_code
						|| rsp.month_code !== want.month_code
						|| rsp.day_code !== want.day_code
						|| rsp.hour_code !== want.hour_code
						|| rsp.minute_code !== want.minute_code) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("mismatch at beat %0d", replies_seen);
							$display("  want %s", fmt_reply(want));
							$display("  got  %s", fmt_reply(rsp));
						end
					end
				end
				replies_seen++;
			end
			stuck = moved ? 0 : stuck + 1;
		end
	end

	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (stuck < STALL_LIMIT) @(posedge clk);
		$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : rsp_side
		int n;
		forever begin
			if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			n = rx_burst ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	task automatic send_beat(input stim_t it);
		int gap;
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it.beat;
		cur_item  <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		beats_sent++;
	endtask

	task automatic send_byte(input cmd_t op, input logic [7:0] b);
		send_beat(row(op, b, 1'b0, ST_IN_FRAME, 8'd0));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (replies_seen != beats_sent) @(posedge clk);
	endtask

	task automatic send_frame(input int n, input bit good);
		logic [7:0] sum;
		logic [7:0] d;
		sum = 8'(n);
		send_byte(CMD_BYTE, HEADER_BYTE);
		send_byte(CMD_BYTE, 8'(n));
		for (int i = 0; i < n * REC_LEN + END_OFS - 2; i++) begin
			d = 8'($urandom_range(0, 255));
			sum = sum + d;
			send_byte(CMD_BYTE, d);
		end
		if (good) send_byte(CMD_BYTE, sum);
		else send_byte(CMD_BYTE, sum ^ 8'($urandom_range(1, 255)));
	endtask

	initial begin : stimulus
		int rnd_start;
		int kind;
		int n;
		logic [7:0] b;
		clear_frame();
		cur_item = row(CMD_BYTE, 8'd0, 1'b0, ST_IN_FRAME, 8'd0);

		// restart, bad headers, N=0 good frame, after frame, N=0 bad checksum
		dir_tab.push_back(row(CMD_RESTART, 8'hFF, 1'b1, ST_RESTART, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b1, ST_BAD_HEADER, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'hFF, 1'b1, ST_BAD_HEADER, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, HEADER_BYTE, 1'b1, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b1, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'hFF, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'hFF, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h01, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h01, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b1, ST_FRAME_OK, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'hFF, 1'b1, ST_AFTER, 8'd0));
		dir_tab.push_back(row(CMD_RESTART, 8'h00, 1'b1, ST_RESTART, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, HEADER_BYTE, 1'b1, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h00, 1'b1, ST_IN_FRAME, 8'd0));
		repeat (6) dir_tab.push_back(row(CMD_BYTE, 8'h10, 1'b0, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, 8'h61, 1'b1, ST_BAD_SUM, 8'd0));
		dir_tab.push_back(row(CMD_BYTE, HEADER_BYTE, 1'b1, ST_IN_FRAME, 8'd0));
		dir_tab.push_back(row(CMD_RESTART, 8'hA5, 1'b1, ST_RESTART, 8'd0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) send_beat(dir_tab[i]);
		drain();

		rnd_start = beats_sent;
		while (beats_sent - rnd_start < RAND_BEATS) begin
			if ($urandom_range(0, 9) != 0) send_byte(CMD_RESTART, 8'($urandom_range(0, 255)));
			kind = $urandom_range(0, 99);
			n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
			if (kind < 60) begin
				send_frame(n, 1'b1);
				repeat ($urandom_range(0, 2)) send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
			end else if (kind < 75) begin
				send_frame(n, 1'b0);
			end else if (kind < 85) begin
				send_byte(CMD_BYTE, HEADER_BYTE);
				send_byte(CMD_BYTE, 8'(n));
				repeat ($urandom_range(0, n * REC_LEN + 5))
					send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
			end else if (kind < 92) begin
				b = 8'($urandom_range(0, 254));
				if (b >= HEADER_BYTE) b = b + 8'd1;
				send_byte(CMD_BYTE, b);
				send_frame(n, 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end
		drain();

		// larger count, then trailing bytes after the frame
		send_byte(CMD_RESTART, 8'($urandom_range(0, 255)));
		send_frame(20, 1'b1);
		repeat (12) send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));

		drain();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && reply_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
